/* design/qslerp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, types and the arctangent table of the slerp unit.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  localparam int DOT_W  = 34;            // Q28 sum of four products
  localparam int DCL_W  = 29;            // clamped dot, at most 1.0 in Q28
  localparam int Q16_W  = 17;
  localparam int CFG_AW = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [Q16_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [Q16_W-1:0] THRESH_RESET = 17'd65503;
  localparam logic [DCL_W-1:0] DOT_ONE      = 29'h1000_0000;
  localparam logic [0:0]       REG_THRESH   = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314856;
      1:  r = 30'd497837829;
      2:  r = 30'd263043836;
      3:  r = 30'd133525158;
      4:  r = 30'd67021686;
      5:  r = 30'd33543515;
      6:  r = 30'd16775850;
      7:  r = 30'd8388437;
      8:  r = 30'd4194282;
      9:  r = 30'd2097149;
      10: r = 30'd1048575;
      11: r = 30'd524287;
      12: r = 30'd262143;
      13: r = 30'd131071;
      14: r = 30'd65535;
      15: r = 30'd32767;
      16: r = 30'd16383;
      17: r = 30'd8191;
      18: r = 30'd4095;
      19: r = 30'd2047;
      20: r = 30'd1023;
      21: r = 30'd511;
      22: r = 30'd255;
      23: r = 30'd127;
      24: r = 30'd63;
      25: r = 30'd31;
      26: r = 30'd15;
      27: r = 30'd7;
      28: r = 30'd3;
      29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/quat_slerp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_slerp_unit
// Fixed-point quaternion slerp with a linear fallback near coincidence.
// ----------------------------------------------------------------------------
// Input beat: two quaternions a, b (signed Q1.14) and blend t (Q1.16,
// values above 1.0 act as 1.0). Output beat: the blended quaternion,
// rounded and saturated, plus took_linear when the weights were 1-t and t.
// A beat is taken on a clock edge with valid high and stall low.
// The dot threshold for the linear path is set over the APB port at byte
// address 0; write it only while the unit is empty.
// Throughput: one beat per cycle while out_stall is low and the queue has
// room. The path runs through the 31-stage square root, the vectoring and
// rotation CORDIC pipelines and the 16-stage weight dividers.
// A front end (dot product, arc and path choice) feeds a four-entry queue;
// the arithmetic pipeline behind it halts as a whole while out_stall holds a
// waiting result, and the front end keeps taking beats until the queue and
// its own stages fill. Synchronous reset empties the pipeline and the queue
// and sets the threshold to 65503.
// ----------------------------------------------------------------------------
module quat_slerp_unit #(
  parameter int COMP_WIDTH      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qslerp_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] a_w,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  input  logic signed [COMP_WIDTH-1:0] b_w,
  input  logic [16:0]                  blend,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic signed [COMP_WIDTH-1:0] out_w,
  output logic                         took_linear
);

  localparam int NIT = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam int QW  = 9 * COMP_WIDTH + 51;

  logic [16:0]        thresh;
  logic               thr_sel;
  logic               q_push, q_pop;
  logic [QW-1:0]      q_wdata, q_rdata;
  qslerp_pkg::qstat_t q_stat;

  assign pready  = 1'b1;
  assign thr_sel = (paddr[2] == qslerp_pkg::REG_THRESH);
  assign prdata  = thr_sel ? {15'd0, thresh} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= qslerp_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && pready && thr_sel) begin
      thresh <= pwdata[16:0];
    end
  end

  qslerp_front #(.CW(COMP_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .a_w       (a_w),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .b_w       (b_w),
    .blend     (blend),
    .thresh    (thresh),
    .qstat     (q_stat),
    .push      (q_push),
    .push_data (q_wdata)
  );

  qslerp_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  qslerp_back #(.CW(COMP_WIDTH), .NIT(NIT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (q_stat),
    .head        (q_rdata),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_w       (out_w),
    .took_linear (took_linear)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_stat.empty)
    else $error("queue both full and empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> q_stat.empty && !out_valid)
    else $error("state left after reset");

endmodule

/* design/qslerp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_queue
// Short FIFO between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module qslerp_queue #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [W-1:0]        wdata,
  input  logic                pop,
  output logic [W-1:0]        rdata,
  output qslerp_pkg::qstat_t  stat
);

  logic [W-1:0]                  mem [qslerp_pkg::QDEPTH];
  logic [qslerp_pkg::QPTR_W-1:0] wp, rp;
  logic [qslerp_pkg::QPTR_W:0]   cnt;

  assign rdata      = mem[rp];
  assign stat.full  = (cnt == (qslerp_pkg::QPTR_W + 1)'(qslerp_pkg::QDEPTH));
  assign stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

/* design/qslerp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_front
// Takes input beats, forms the dot product, picks the short arc and the
// linear or trigonometric path, and pushes the classified item to the queue.
// ----------------------------------------------------------------------------
module qslerp_front #(
  parameter int CW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CW-1:0]        a_x,
  input  logic signed [CW-1:0]        a_y,
  input  logic signed [CW-1:0]        a_z,
  input  logic signed [CW-1:0]        a_w,
  input  logic signed [CW-1:0]        b_x,
  input  logic signed [CW-1:0]        b_y,
  input  logic signed [CW-1:0]        b_z,
  input  logic signed [CW-1:0]        b_w,
  input  logic [16:0]                 blend,
  input  logic [16:0]                 thresh,
  input  qslerp_pkg::qstat_t          qstat,
  output logic                        push,
  output logic [9*CW+50:0]            push_data
);

  localparam int FRAC = CW - 2;
  localparam int SR   = (2 * FRAC >= 28) ? 2 * FRAC - 28 : 0;
  localparam int SL   = (2 * FRAC < 28) ? 28 - 2 * FRAC : 0;
  localparam int BW   = 2 * CW + 32;
  localparam int DW   = qslerp_pkg::DOT_W;
  localparam int B_LO = 4 * CW;
  localparam int D_LO = 8 * CW + 4;
  localparam int T_LO = D_LO + qslerp_pkg::DCL_W;
  localparam int L_BIT = T_LO + qslerp_pkg::Q16_W;

  logic signed [CW-1:0]   ain [4];
  logic signed [CW-1:0]   bin [4];
  logic                   f1v, f2v;
  logic signed [2*CW-1:0] prod [4];
  logic signed [CW-1:0]   fa [4];
  logic signed [CW-1:0]   fb [4];
  logic [16:0]            ft;
  logic                   f1_load, f2_load;

  logic signed [BW-1:0]   ext [4];
  logic signed [BW-1:0]   shf [4];
  logic signed [DW-1:0]   dsum;
  logic [DW-1:0]          absd;
  logic                   neg, lin;
  logic [qslerp_pkg::DCL_W-1:0] dcl;
  logic signed [CW:0]     bneg [4];
  logic [9*CW+50:0]       pk;

  assign ain = '{a_x, a_y, a_z, a_w};
  assign bin = '{b_x, b_y, b_z, b_w};

  assign push     = f2v && !qstat.full;
  assign f2_load  = !f2v || push;
  assign f1_load  = !f1v || f2_load;
  assign in_stall = !f1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
    end else begin
      if (f1_load) begin
        f1v <= in_valid;
      end
      if (f2_load) begin
        f2v <= f1v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_load && in_valid) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= (2 * CW)'(ain[k]) * (2 * CW)'(bin[k]);
        fa[k]   <= ain[k];
        fb[k]   <= bin[k];
      end
      ft <= (blend > qslerp_pkg::ONE_Q16) ? qslerp_pkg::ONE_Q16 : blend;
    end
  end

  always_comb begin
    dsum = '0;
    for (int k = 0; k < 4; k++) begin
      ext[k] = BW'(prod[k]);
      shf[k] = (ext[k] <<< SL) >>> SR;
      dsum   = dsum + shf[k][DW-1:0];
    end
    neg  = dsum[DW-1];
    absd = neg ? DW'(-dsum) : DW'(dsum);
    lin  = absd > DW'({thresh, 12'd0});
    dcl  = (absd > DW'(qslerp_pkg::DOT_ONE)) ? qslerp_pkg::DOT_ONE
                                               : absd[qslerp_pkg::DCL_W-1:0];
    pk   = '0;
    for (int k = 0; k < 4; k++) begin
      bneg[k] = neg ? -(CW + 1)'(fb[k]) : (CW + 1)'(fb[k]);
      pk[k * CW +: CW]              = fa[k];
      pk[B_LO + k * (CW + 1) +: CW + 1] = bneg[k];
    end
    pk[D_LO +: qslerp_pkg::DCL_W] = dcl;
    pk[T_LO +: qslerp_pkg::Q16_W] = ft;
    pk[L_BIT]                     = lin;
  end

  always_ff @(posedge clk) begin
    if (f2_load && f1v) begin
      push_data <= pk;
    end
  end

endmodule

/* design/qslerp_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic
// Pipelined CORDIC, one micro-rotation per stage. Vectoring returns the
// angle, rotation returns the scaled sine.
// ----------------------------------------------------------------------------
module qslerp_cordic #(
  parameter int NIT = 16,
  parameter bit VEC = 1'b0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [35:0] x0,
  input  logic signed [35:0] y0,
  input  logic signed [33:0] z0,
  output logic signed [35:0] res
);

  logic signed [35:0] xs [1:NIT];
  logic signed [35:0] ys [1:NIT];
  logic signed [33:0] zs [1:NIT];

  for (genvar i = 0; i < NIT; i++) begin : g_step
    localparam logic signed [33:0] AT = 34'(qslerp_pkg::atan_q30(i));
    logic signed [35:0] xi, yi, dx, dy;
    logic signed [33:0] zi;
    logic               dpos;
    if (i == 0) begin : g_src0
      assign xi = x0;
      assign yi = y0;
      assign zi = z0;
    end else begin : g_srcn
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
    end
    assign dx   = yi >>> i;
    assign dy   = xi >>> i;
    assign dpos = VEC ? !(yi > 0) : (zi >= 0);

    always_ff @(posedge clk) begin
      if (en) begin
        ys[i+1] <= dpos ? yi + dy : yi - dy;
        zs[i+1] <= dpos ? zi - AT : zi + AT;
      end
    end
    if (i < NIT - 1) begin : g_x
      always_ff @(posedge clk) begin
        if (en) begin
          xs[i+1] <= dpos ? xi - dx : xi + dx;
        end
      end
    end
  end

  assign res = VEC ? 36'(zs[NIT]) : ys[NIT];

endmodule

/* design/qslerp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_back
// Arithmetic pipeline: sine of theta by square root, theta by CORDIC,
// three CORDIC sines, two dividers for the weights, then the blend.
// ----------------------------------------------------------------------------
module qslerp_back #(
  parameter int CW  = 16,
  parameter int NIT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qslerp_pkg::qstat_t   qstat,
  input  logic [9*CW+50:0]     head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output logic signed [CW-1:0] out_w,
  output logic                 took_linear
);

  localparam int QW    = 9 * CW + 51;
  localparam int B_LO  = 4 * CW;
  localparam int D_LO  = 8 * CW + 4;
  localparam int T_LO  = D_LO + qslerp_pkg::DCL_W;
  localparam int L_BIT = T_LO + qslerp_pkg::Q16_W;

  localparam int P_RAD  = 2;
  localparam int P_SQRT = P_RAD + 31;
  localparam int P_VEC  = P_SQRT + NIT;
  localparam int P_TH   = P_VEC + 1;
  localparam int P_ANG  = P_TH + 1;
  localparam int P_ROT  = P_ANG + NIT;
  localparam int P_D0   = P_ROT + 1;
  localparam int P_DIV  = P_D0 + 16;
  localparam int P_MUL  = P_DIV + 1;
  localparam int L      = P_MUL + 1;

  localparam logic signed [CW+3:0] MAXV = {5'b00000, {(CW - 1){1'b1}}};
  localparam logic signed [CW+3:0] MINV = {5'b11111, {(CW - 1){1'b0}}};

  logic            en;
  logic            v  [1:L];
  logic [QW-1:0]   sc [1:L];
  logic            lf [1:L];
  logic [L-1:1]    lfs;

  assign en  = !(v[L] && out_stall);
  assign pop = en && !qstat.empty;

  for (genvar k = 1; k <= L; k++) begin : g_chain
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en) begin
          v[k] <= !qstat.empty;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sc[k] <= head;
          lf[k] <= head[L_BIT];
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en) begin
          v[k] <= v[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sc[k] <= sc[k-1];
          lf[k] <= lf[k-1] | lfs[k-1];
        end
      end
    end
  end

  // sqrt(1 - dot^2), one result bit per stage
  logic [30:0] d30_in;
  logic [61:0] sq;
  logic [61:0] sv [0:30];
  logic [61:0] sr [1:31];

  assign d30_in = {head[D_LO +: qslerp_pkg::DCL_W], 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      sq    <= 62'(d30_in) * 62'(d30_in);
      sv[0] <= (62'(1) << 60) - sq;
    end
  end

  for (genvar j = 0; j < 31; j++) begin : g_sqrt
    localparam logic [61:0] BB = 62'(1) << (60 - 2 * j);
    logic [61:0] r_in, trial;
    logic        take;
    if (j == 0) begin : g_r0
      assign r_in = '0;
    end else begin : g_rn
      assign r_in = sr[j];
    end
    assign trial = r_in + BB;
    assign take  = sv[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sr[j+1] <= take ? (r_in >> 1) + BB : r_in >> 1;
      end
    end
    if (j < 30) begin : g_v
      always_ff @(posedge clk) begin
        if (en) begin
          sv[j+1] <= take ? sv[j] - trial : sv[j];
        end
      end
    end
  end

  // theta
  logic signed [35:0] vres;
  logic [31:0]        th, thd;
  logic [48:0]        pa, pb;
  logic [16:0]        t_th;

  qslerp_cordic #(.NIT(NIT), .VEC(1'b1)) u_vec (
    .clk (clk),
    .en  (en),
    .x0  (36'({sc[P_SQRT][D_LO +: qslerp_pkg::DCL_W], 2'b00})),
    .y0  (36'(sr[31][30:0])),
    .z0  ('0),
    .res (vres)
  );

  assign t_th = sc[P_TH][T_LO +: qslerp_pkg::Q16_W];

  always_ff @(posedge clk) begin
    if (en) begin
      th  <= vres[35] ? '0 : vres[31:0];
      pa  <= 49'(th) * 49'(qslerp_pkg::ONE_Q16 - t_th);
      pb  <= 49'(th) * 49'(t_th);
      thd <= th;
    end
  end

  // sines
  logic signed [35:0] den, na, nb;

  qslerp_cordic #(.NIT(NIT), .VEC(1'b0)) u_den (
    .clk (clk), .en (en), .x0 (36'sd1 <<< 30), .y0 ('0),
    .z0 (34'(thd)), .res (den)
  );
  qslerp_cordic #(.NIT(NIT), .VEC(1'b0)) u_sina (
    .clk (clk), .en (en), .x0 (36'sd1 <<< 30), .y0 ('0),
    .z0 (34'(pa[48:16])), .res (na)
  );
  qslerp_cordic #(.NIT(NIT), .VEC(1'b0)) u_sinb (
    .clk (clk), .en (en), .x0 (36'sd1 <<< 30), .y0 ('0),
    .z0 (34'(pb[48:16])), .res (nb)
  );

  always_comb begin
    lfs         = '0;
    lfs[P_SQRT] = (sr[31] == '0);
    lfs[P_ROT]  = (den <= 0);
  end

  // weights: floor(num * 65536 / den), 1 quotient bit per stage
  logic signed [35:0] num [2];
  logic [30:0]        ddr [0:15];
  logic [16:0]        wt [2];

  assign num[0] = na;
  assign num[1] = nb;

  always_ff @(posedge clk) begin
    if (en) begin
      ddr[0] <= den[30:0];
    end
  end

  for (genvar j = 0; j < 15; j++) begin : g_dd
    always_ff @(posedge clk) begin
      if (en) begin
        ddr[j+1] <= ddr[j];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [30:0] rem [0:15];
    logic [15:0] q   [1:16];
    logic        fz  [0:16];
    logic        ff  [0:16];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[0] <= num[l][30:0];
        fz[0]  <= num[l] <= 0;
        ff[0]  <= num[l] >= den;
      end
    end

    for (genvar j = 0; j < 16; j++) begin : g_div
      logic [31:0] r2;
      logic [15:0] q_in;
      logic        ge;
      if (j == 0) begin : g_q0
        assign q_in = '0;
      end else begin : g_qn
        assign q_in = q[j];
      end
      assign r2 = {rem[j], 1'b0};
      assign ge = r2 >= 32'(ddr[j]);
      always_ff @(posedge clk) begin
        if (en) begin
          q[j+1]  <= {q_in[14:0], ge};
          fz[j+1] <= fz[j];
          ff[j+1] <= ff[j];
        end
      end
      if (j < 15) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[j+1] <= ge ? 31'(r2 - 32'(ddr[j])) : r2[30:0];
          end
        end
      end
    end

    assign wt[l] = ff[16] ? qslerp_pkg::ONE_Q16 : (fz[16] ? '0 : {1'b0, q[16]});
  end

  // blend
  logic [16:0]           t_m, wa, wb;
  logic signed [CW+17:0] ma [4];
  logic signed [CW+18:0] mb [4];
  logic signed [CW+19:0] acc [4];
  logic signed [CW+3:0]  shv [4];
  logic signed [CW-1:0]  res [4];

  assign t_m = sc[P_DIV][T_LO +: qslerp_pkg::Q16_W];
  assign wa  = lf[P_DIV] ? qslerp_pkg::ONE_Q16 - t_m : wt[0];
  assign wb  = lf[P_DIV] ? t_m : wt[1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ma[k] <= (CW + 18)'($signed({1'b0, wa}))
               * (CW + 18)'($signed(sc[P_DIV][k * CW +: CW]));
        mb[k] <= (CW + 19)'($signed({1'b0, wb}))
               * (CW + 19)'($signed(sc[P_DIV][B_LO + k * (CW + 1) +: CW + 1]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k] = (CW + 20)'(ma[k]) + (CW + 20)'(mb[k]) + (CW + 20)'(32768);
      shv[k] = acc[k][CW+19:16];
      if (shv[k] > MAXV) begin
        res[k] = MAXV[CW-1:0];
      end else if (shv[k] < MINV) begin
        res[k] = MINV[CW-1:0];
      end else begin
        res[k] = shv[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_w <= res[3];
    end
  end

  assign out_valid   = v[L];
  assign took_linear = lf[L];

endmodule
